// ===== src/gsdf_pkg.sv =====
// shared types, constants and tables for the gsdf luminance to jnd index unit
`timescale 1ns / 1ps
`default_nettype none

package gsdf_pkg;

	// field widths and fixed-point formats
	localparam int LUM_W          = 32;
	localparam int JND_W          = 21;
	localparam int LUM_FRAC_BITS  = 16;
	localparam int OUT_FRAC_BITS  = 8;
	localparam int LOG_TABLE_BITS = 8;
	localparam int QF             = 30;

	// log2 front end widths
	localparam int POS_W     = $clog2(LUM_W);
	localparam int MANT_W    = LUM_W - 1;
	localparam int REM_W     = MANT_W - LOG_TABLE_BITS;
	localparam int ROM_DEPTH = (1 << LOG_TABLE_BITS) + 1;
	localparam int ROM_AW    = LOG_TABLE_BITS + 1;
	localparam int ROM_W     = QF + 1;
	// neighbor entries differ by less than 1.45 * 2^(QF - LOG_TABLE_BITS)
	localparam int DIFF_W    = QF + 1 - LOG_TABLE_BITS;
	localparam int EXP_W     = POS_W + 1;
	localparam int L2_W      = EXP_W + QF;
	localparam int L2_MAG_W  = L2_W - 1;
	localparam int LOG10_2_W = 29;

	// horner datapath: |log10 L| < 4.9 and every partial sum stays below 2^15
	localparam int T_MAG_W   = 33;
	localparam int ACC_W     = 47;
	localparam int ACC_MAG_W = ACC_W - 1;
	localparam int ACC_HALF  = ACC_MAG_W / 2;
	localparam int PP_W      = ACC_HALF + T_MAG_W;
	localparam int STEPS     = 8;

	// log10(2) in q.30, rounded to nearest
	localparam logic [LOG10_2_W-1:0] LOG10_2_Q =
		LOG10_2_W'(((64'd3010299957 << QF) + 64'd5000000000) / 64'd10000000000);

	// gsdf polynomial coefficients in q.30, rounded to nearest
	localparam logic signed [ACC_W-1:0] GSDF_C0 =
		ACC_W'(((64'd71498068 << QF) + 64'd500000) / 64'd1000000);
	localparam logic signed [ACC_W-1:0] GSDF_C1 =
		ACC_W'(((64'd94593053 << QF) + 64'd500000) / 64'd1000000);
	localparam logic signed [ACC_W-1:0] GSDF_C2 =
		ACC_W'(((64'd41912053 << QF) + 64'd500000) / 64'd1000000);
	localparam logic signed [ACC_W-1:0] GSDF_C3 =
		ACC_W'(((64'd98247004 << QF) + 64'd5000000) / 64'd10000000);
	localparam logic signed [ACC_W-1:0] GSDF_C4 =
		ACC_W'(((64'd28175407 << QF) + 64'd50000000) / 64'd100000000);
	localparam logic signed [ACC_W-1:0] GSDF_C5 =
		ACC_W'(64'd0 - (((64'd11878455 << QF) + 64'd5000000) / 64'd10000000));
	localparam logic signed [ACC_W-1:0] GSDF_C6 =
		ACC_W'(64'd0 - (((64'd18014349 << QF) + 64'd50000000) / 64'd100000000));
	localparam logic signed [ACC_W-1:0] GSDF_C7 =
		ACC_W'(((64'd14710899 << QF) + 64'd50000000) / 64'd100000000);
	localparam logic signed [ACC_W-1:0] GSDF_C8 =
		ACC_W'(64'd0 - (((64'd17046845 << QF) + 64'd500000000) / 64'd1000000000));

	// index reported for zero luminance: -1.0
	localparam logic signed [JND_W-1:0] JND_INVALID = JND_W'(-(1 << OUT_FRAC_BITS));

	// word passed between horner steps
	typedef struct packed {
		logic                      zero;
		logic                      t_neg;
		logic [T_MAG_W-1:0]        t_mag;
		logic signed [ACC_W-1:0]   acc;
	} horner_t;

	typedef logic [ROM_DEPTH-1:0][ROM_W-1:0] log2_rom_t;

	// coefficient of the power k of log10(L)
	function automatic logic signed [ACC_W-1:0] gsdf_coef(input int unsigned k);
		logic signed [ACC_W-1:0] c;
		case (k)
			0:       c = GSDF_C0;
			1:       c = GSDF_C1;
			2:       c = GSDF_C2;
			3:       c = GSDF_C3;
			4:       c = GSDF_C4;
			5:       c = GSDF_C5;
			6:       c = GSDF_C6;
			7:       c = GSDF_C7;
			8:       c = GSDF_C8;
			default: c = '0;
		endcase
		return c;
	endfunction

	// mantissa table log2(1 + k/2^LOG_TABLE_BITS) in q1.30 by repeated squaring
	function automatic log2_rom_t build_log2_rom();
		log2_rom_t         rom;
		logic [63:0]       m;
		logic [ROM_W-1:0]  r;
		for (int k = 0; k < ROM_DEPTH; k++) begin
			if (k == ROM_DEPTH - 1) begin
				r = ROM_W'(1) << QF;
			end else begin
				m = (64'd1 << QF) + (64'(k) << (QF - LOG_TABLE_BITS));
				r = '0;
				for (int b = QF - 1; b >= 0; b--) begin
					m = (m * m + (64'd1 << (QF - 1))) >> QF;
					if (m >= (64'd2 << QF)) begin
						m = m >> 1;
						r[b] = 1'b1;
					end
				end
			end
			rom[k] = r;
		end
		return rom;
	endfunction

	localparam log2_rom_t LOG2_ROM = build_log2_rom();

endpackage

`default_nettype wire

// ===== src/gsdf_lum_if.sv =====
// stream channel that carries luminance words
`timescale 1ns / 1ps
`default_nettype none

interface gsdf_lum_if;
	logic                          valid;
	logic                          ready;
	logic [gsdf_pkg::LUM_W-1:0]    luminance;

	modport source (output valid, output luminance, input ready);
	modport sink (input valid, input luminance, output ready);
endinterface

`default_nettype wire

// ===== src/gsdf_jnd_if.sv =====
// stream channel that carries jnd index words
`timescale 1ns / 1ps
`default_nettype none

interface gsdf_jnd_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [gsdf_pkg::JND_W-1:0]    jnd_index;
	logic                                 index_valid;

	modport source (output valid, output jnd_index, output index_valid, input ready);
	modport sink (input valid, input jnd_index, input index_valid, output ready);
endinterface

`default_nettype wire

// ===== src/gsdf_log_front.sv =====
// log10 front end: leading one, mantissa table, interpolation, scale by log10(2)
`timescale 1ns / 1ps
`default_nettype none

module gsdf_log_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          lum_valid,
	output logic                               lum_ready,
	input  wire logic [gsdf_pkg::LUM_W-1:0]    luminance,
	output logic                               hs_valid,
	input  wire logic                          hs_ready,
	output gsdf_pkg::horner_t                  hs
);
	import gsdf_pkg::*;

	localparam int IP_W = DIFF_W + REM_W + 1;
	localparam int LP_W = L2_MAG_W + LOG10_2_W;
	localparam logic [IP_W-1:0]   IP_HALF = IP_W'(1) << (REM_W - 1);
	localparam logic [LP_W:0]     LP_HALF = (LP_W + 1)'(1) << (QF - 1);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6;

	logic [LUM_W-1:0]          x_s1;
	logic [POS_W-1:0]          p_s1, p_s2, p_s3;
	logic                      zero_s1, zero_s2, zero_s3, zero_s4, zero_s5, zero_s6;
	logic [LOG_TABLE_BITS-1:0] idx_s2;
	logic [REM_W-1:0]          rem_s2, rem_s3;
	logic [ROM_W-1:0]          lo_s3;
	logic [DIFF_W-1:0]         diff_s3;
	logic [L2_W-1:0]           l2_s4;
	logic [LP_W-1:0]           lp_s5;
	logic                      neg_s5, neg_s6;
	logic [T_MAG_W-1:0]        tmag_s6;

	logic [POS_W-1:0]          lead;
	logic [LUM_W-1:0]          norm;
	logic [ROM_AW-1:0]         addr_lo, addr_hi;
	logic [ROM_W-1:0]          rom_lo, rom_hi;
	logic [IP_W-2:0]           ip;
	logic [IP_W-1:0]           ip_sum;
	logic [ROM_W-1:0]          frac;
	logic [EXP_W-1:0]          expo;
	logic [L2_W-1:0]           l2;
	logic [L2_MAG_W-1:0]       l2_mag;
	logic [LP_W-1:0]           lp;
	logic [LP_W:0]             t_sum;

	// ready chain: a stage takes a word when empty or when it drains
	assign rdy_s6    = !v_s6 || hs_ready;
	assign rdy_s5    = !v_s5 || rdy_s6;
	assign rdy_s4    = !v_s4 || rdy_s5;
	assign rdy_s3    = !v_s3 || rdy_s4;
	assign rdy_s2    = !v_s2 || rdy_s3;
	assign rdy_s1    = !v_s1 || rdy_s2;
	assign lum_ready = rdy_s1;

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= lum_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
			if (rdy_s6) v_s6 <= v_s5;
		end
	end

	// s1: leading one position
	always_comb begin
		lead = '0;
		for (int b = 1; b < LUM_W; b++) begin
			if (luminance[b]) lead = POS_W'(b);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && lum_valid) begin
			x_s1    <= luminance;
			p_s1    <= lead;
			zero_s1 <= (luminance == '0);
		end
	end

	// s2: normalize, split mantissa into table index and remainder
	assign norm = x_s1 << (POS_W'(LUM_W - 1) - p_s1);

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			idx_s2  <= norm[MANT_W-1 -: LOG_TABLE_BITS];
			rem_s2  <= norm[REM_W-1:0];
			p_s2    <= p_s1;
			zero_s2 <= zero_s1;
		end
	end

	// s3: table lookup of both neighbors
	assign addr_lo = {1'b0, idx_s2};
	assign addr_hi = addr_lo + ROM_AW'(1);
	assign rom_lo  = LOG2_ROM[addr_lo];
	assign rom_hi  = LOG2_ROM[addr_hi];

	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) begin
			lo_s3   <= rom_lo;
			diff_s3 <= DIFF_W'(rom_hi - rom_lo);
			rem_s3  <= rem_s2;
			p_s3    <= p_s2;
			zero_s3 <= zero_s2;
		end
	end

	// s4: interpolate, round half up, add the exponent
	assign ip     = diff_s3 * rem_s3;
	assign ip_sum = {1'b0, ip} + IP_HALF;
	assign frac   = lo_s3 + ROM_W'(ip_sum >> REM_W);
	assign expo   = EXP_W'(p_s3) - EXP_W'(LUM_FRAC_BITS);
	assign l2     = {expo, {QF{1'b0}}} + L2_W'(frac);

	always_ff @(posedge clk) begin
		if (rdy_s4 && v_s3) begin
			l2_s4   <= l2;
			zero_s4 <= zero_s3;
		end
	end

	// s5: magnitude times log10(2)
	assign l2_mag = L2_MAG_W'(l2_s4[L2_W-1] ? (L2_W'(0) - l2_s4) : l2_s4);
	assign lp     = l2_mag * LOG10_2_Q;

	always_ff @(posedge clk) begin
		if (rdy_s5 && v_s4) begin
			lp_s5   <= lp;
			neg_s5  <= l2_s4[L2_W-1];
			zero_s5 <= zero_s4;
		end
	end

	// s6: round to q.30, keep sign and magnitude apart
	assign t_sum = {1'b0, lp_s5} + LP_HALF;

	always_ff @(posedge clk) begin
		if (rdy_s6 && v_s5) begin
			tmag_s6 <= T_MAG_W'(t_sum >> QF);
			neg_s6  <= neg_s5;
			zero_s6 <= zero_s5;
		end
	end

	// horner starts from the top coefficient
	assign hs_valid = v_s6;
	assign hs.zero  = zero_s6;
	assign hs.t_neg = neg_s6;
	assign hs.t_mag = tmag_s6;
	assign hs.acc   = GSDF_C8;

endmodule

`default_nettype wire

// ===== src/gsdf_horner_step.sv =====
// one horner step: acc * t rounded to q.30, plus the next coefficient
`timescale 1ns / 1ps
`default_nettype none

module gsdf_horner_step (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cur_valid,
	output logic                                        cur_ready,
	input  wire gsdf_pkg::horner_t                      cur,
	input  wire logic signed [gsdf_pkg::ACC_W-1:0]      coef,
	output logic                                        nxt_valid,
	input  wire logic                                   nxt_ready,
	output gsdf_pkg::horner_t                           nxt
);
	import gsdf_pkg::*;

	localparam int SUM_W = PP_W + ACC_HALF + 1;
	localparam logic [SUM_W-1:0] RND_HALF = SUM_W'(1) << (QF - 1);

	logic v_s1, v_s2;
	logic rdy_s1, rdy_s2;

	logic                  acc_neg;
	logic [ACC_MAG_W-1:0]  acc_mag;
	logic [PP_W-1:0]       pp_lo, pp_hi;
	logic [PP_W-1:0]       pp_lo_s1, pp_hi_s1;
	logic                  neg_s1;
	horner_t               pass_s1;

	logic [SUM_W-1:0]      sum;
	logic [ACC_W-1:0]      r;
	logic [ACC_W-1:0]      prod;
	horner_t               nxt_s2;

	assign rdy_s2    = !v_s2 || nxt_ready;
	assign rdy_s1    = !v_s1 || rdy_s2;
	assign cur_ready = rdy_s1;

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= cur_valid;
			if (rdy_s2) v_s2 <= v_s1;
		end
	end

	// s1: two partial products of |acc| and |t|
	assign acc_neg = cur.acc[ACC_W-1];
	assign acc_mag = ACC_MAG_W'(acc_neg ? -cur.acc : cur.acc);
	assign pp_lo   = acc_mag[ACC_HALF-1:0] * cur.t_mag;
	assign pp_hi   = acc_mag[ACC_MAG_W-1:ACC_HALF] * cur.t_mag;

	always_ff @(posedge clk) begin
		if (rdy_s1 && cur_valid) begin
			pp_lo_s1 <= pp_lo;
			pp_hi_s1 <= pp_hi;
			neg_s1   <= acc_neg ^ cur.t_neg;
			pass_s1  <= cur;
		end
	end

	// s2: combine, round half away from zero, apply sign, add coefficient
	assign sum  = {1'b0, pp_hi_s1, {ACC_HALF{1'b0}}} + SUM_W'(pp_lo_s1) + RND_HALF;
	assign r    = ACC_W'(sum >> QF);
	assign prod = neg_s1 ? (ACC_W'(0) - r) : r;

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			nxt_s2.zero  <= pass_s1.zero;
			nxt_s2.t_neg <= pass_s1.t_neg;
			nxt_s2.t_mag <= pass_s1.t_mag;
			nxt_s2.acc   <= $signed(prod) + coef;
		end
	end

	assign nxt_valid = v_s2;
	assign nxt       = nxt_s2;

endmodule

`default_nettype wire

// ===== src/gsdf_out_stage.sv =====
// output register: round to the output format, saturate, mark zero input
`timescale 1ns / 1ps
`default_nettype none

module gsdf_out_stage (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                hs_valid,
	output logic                                     hs_ready,
	input  wire gsdf_pkg::horner_t                   hs,
	output logic                                     jnd_valid,
	input  wire logic                                jnd_ready,
	output logic signed [gsdf_pkg::JND_W-1:0]        jnd_index,
	output logic                                     index_valid
);
	import gsdf_pkg::*;

	localparam int SH   = QF - OUT_FRAC_BITS;
	localparam int JM_W = ACC_W - SH;
	localparam logic [ACC_W-1:0] RND_HALF = ACC_W'(1) << (SH - 1);
	localparam logic [JM_W-1:0]  POS_LIM  = JM_W'((1 << (JND_W - 1)) - 1);
	localparam logic [JM_W-1:0]  NEG_LIM  = JM_W'(1 << (JND_W - 1));

	logic                     v_s1;
	logic                     neg;
	logic [ACC_MAG_W-1:0]     mag;
	logic [ACC_W-1:0]         rsum;
	logic [JM_W-1:0]          jm;
	logic [JND_W-1:0]         j;
	logic signed [JND_W-1:0]  jnd_index_s1;
	logic                     index_valid_s1;

	assign hs_ready = !v_s1 || jnd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (hs_ready) begin
			v_s1 <= hs_valid;
		end
	end

	// round magnitude half away from zero, then clamp to the field
	assign neg  = hs.acc[ACC_W-1];
	assign mag  = ACC_MAG_W'(neg ? -hs.acc : hs.acc);
	assign rsum = {1'b0, mag} + RND_HALF;
	assign jm   = JM_W'(rsum >> SH);

	always_comb begin
		if (hs.zero) begin
			j = JND_INVALID;
		end else if (!neg && (jm > POS_LIM)) begin
			j = JND_W'(POS_LIM);
		end else if (neg && (jm > NEG_LIM)) begin
			j = JND_W'(JM_W'(0) - NEG_LIM);
		end else if (neg) begin
			j = JND_W'(JM_W'(0) - jm);
		end else begin
			j = JND_W'(jm);
		end
	end

	always_ff @(posedge clk) begin
		if (hs_ready && hs_valid) begin
			jnd_index_s1   <= $signed(j);
			index_valid_s1 <= !hs.zero;
		end
	end

	assign jnd_valid   = v_s1;
	assign jnd_index   = jnd_index_s1;
	assign index_valid = index_valid_s1;

endmodule

`default_nettype wire

// ===== src/gsdf_luminance_to_jnd_index_unit.sv =====
// top level: luminance to dicom gsdf jnd index pipeline
//
// Maps an unsigned Q16.16 luminance in cd/m^2 to the grayscale standard display
// function JND index, signed Q12.8, saturated to the 21-bit field; zero luminance
// gives index -1.0 with index_valid low. The pipeline takes one word per clock unless
// jnd.ready stalls it when full; results return in order. Six stages form log10(L)
// (leading one, normalize, mantissa table, interpolation, scale by log10 2,
// rounding), eight two-stage Horner steps evaluate the polynomial with one pair of
// 23x33 multipliers each, and one stage rounds and saturates into the output
// register. Every stage holds its own valid bit, so empty stages keep filling while
// the output waits; lum.ready follows the chain of stage occupancy back from
// jnd.ready within the same cycle.
`timescale 1ns / 1ps
`default_nettype none

module gsdf_luminance_to_jnd_index_unit (
	input  wire logic     clk,
	input  wire logic     arst_n,
	gsdf_lum_if.sink      lum,
	gsdf_jnd_if.source    jnd
);
	import gsdf_pkg::*;

	logic     hs_valid [STEPS+1];
	logic     hs_ready [STEPS+1];
	horner_t  hs       [STEPS+1];

	// log10 front end
	gsdf_log_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.lum_valid (lum.valid),
		.lum_ready (lum.ready),
		.luminance (lum.luminance),
		.hs_valid  (hs_valid[0]),
		.hs_ready  (hs_ready[0]),
		.hs        (hs[0])
	);

	// horner chain, highest power first
	for (genvar i = 0; i < STEPS; i++) begin : g_step
		gsdf_horner_step u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.cur_valid (hs_valid[i]),
			.cur_ready (hs_ready[i]),
			.cur       (hs[i]),
			.coef      (gsdf_coef(STEPS - 1 - i)),
			.nxt_valid (hs_valid[i+1]),
			.nxt_ready (hs_ready[i+1]),
			.nxt       (hs[i+1])
		);
	end

	// rounding, saturation and output register
	gsdf_out_stage u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.hs_valid    (hs_valid[STEPS]),
		.hs_ready    (hs_ready[STEPS]),
		.hs          (hs[STEPS]),
		.jnd_valid   (jnd.valid),
		.jnd_ready   (jnd.ready),
		.jnd_index   (jnd.jnd_index),
		.index_valid (jnd.index_valid)
	);

endmodule

`default_nettype wire

// ===== src/gsdf_checker.sv =====
// port-level checks for the luminance to jnd index unit, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module gsdf_checker (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                lum_valid,
	input  wire logic                                lum_ready,
	input  wire logic                                jnd_valid,
	input  wire logic                                jnd_ready,
	input  wire logic signed [gsdf_pkg::JND_W-1:0]   jnd_index,
	input  wire logic                                index_valid
);
	import gsdf_pkg::*;

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		jnd_valid && !jnd_ready |=> jnd_valid && $stable(jnd_index) && $stable(index_valid))
		else $error("result word changed while stalled");

	// zero luminance reports index -1.0
	a_invalid_code: assert property (@(posedge clk) disable iff (!arst_n)
		jnd_valid && !index_valid |-> jnd_index == JND_INVALID)
		else $error("invalid result without the -1.0 index");

	// a free output never back-pressures the input
	a_in_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(!jnd_valid || jnd_ready) |-> lum_ready)
		else $error("input stalled while output drains");

	// an offered input is refused only while the output is stalled
	a_ready_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		lum_valid && !lum_ready |-> jnd_valid && !jnd_ready)
		else $error("input refused without an output stall");

endmodule

bind gsdf_luminance_to_jnd_index_unit gsdf_checker u_gsdf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.lum_valid   (lum.valid),
	.lum_ready   (lum.ready),
	.jnd_valid   (jnd.valid),
	.jnd_ready   (jnd.ready),
	.jnd_index   (jnd.jnd_index),
	.index_valid (jnd.index_valid)
);

`default_nettype wire

// ===== sim/gsdf_luminance_to_jnd_index_unit_tb.sv =====
// self-checking testbench for the luminance to jnd index unit
`timescale 1ns / 1ps

module gsdf_luminance_to_jnd_index_unit_tb;
	import gsdf_pkg::*;

	localparam int     RAND_WORDS   = 450;
	localparam int     MAX_WAIT     = 13;
	localparam int     DRAIN_CYCLES = 40;
	localparam int     MANT_SH      = LUM_W - 1 - LOG_TABLE_BITS;
	localparam longint JND_MAX      = (longint'(1) <<< (JND_W - 1)) - 1;
	localparam longint JND_MIN      = -(longint'(1) <<< (JND_W - 1));

	// one word on the index channel
	typedef struct packed {
		logic signed [JND_W-1:0] jnd_index;
		logic                    index_valid;
	} jnd_word_t;

	// directed row: the index is typed in only where known marks it
	typedef struct packed {
		logic [LUM_W-1:0]        luminance;
		logic                    known;
		logic signed [JND_W-1:0] jnd_index;
		logic                    index_valid;
	} lum_row_t;

	localparam int N_ROWS = 20;
	localparam lum_row_t LUM_ROWS [N_ROWS] = '{
		'{32'h0000_0000, 1'b1, JND_INVALID, 1'b0},
		'{32'h0000_0001, 1'b1, JND_W'(JND_MIN), 1'b1},
		'{32'h0000_0002, 1'b0, '0, 1'b0},
		'{32'h0000_0003, 1'b0, '0, 1'b0},
		'{32'h0000_0ccd, 1'b0, '0, 1'b0},
		'{32'h0000_8000, 1'b0, '0, 1'b0},
		'{32'h0000_ffff, 1'b0, '0, 1'b0},
		'{32'h0001_0000, 1'b1, 21'sd18304, 1'b1},
		'{32'h0001_0001, 1'b0, '0, 1'b0},
		'{32'h0001_8000, 1'b0, '0, 1'b0},
		'{32'h0001_ffff, 1'b0, '0, 1'b0},
		'{32'h0002_0000, 1'b0, '0, 1'b0},
		'{32'h0064_0000, 1'b0, '0, 1'b0},
		'{32'h0fa0_0000, 1'b0, '0, 1'b0},
		'{32'h5555_5555, 1'b0, '0, 1'b0},
		'{32'haaaa_aaaa, 1'b0, '0, 1'b0},
		'{32'h7fff_ffff, 1'b0, '0, 1'b0},
		'{32'h8000_0000, 1'b0, '0, 1'b0},
		'{32'hffff_ffff, 1'b0, '0, 1'b0},
		'{32'h0000_0000, 1'b1, JND_INVALID, 1'b0}
	};

	logic clk = 1'b0;
	logic arst_n;

	gsdf_lum_if lum_ch ();
	gsdf_jnd_if jnd_ch ();

	gsdf_luminance_to_jnd_index_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.lum    (lum_ch),
		.jnd    (jnd_ch)
	);

	// predictor tables: log2 mantissa, polynomial coefficients, log10(2)
	logic [63:0] log2_tab [0:(1 << LOG_TABLE_BITS)];
	longint      gsdf_c [0:8];
	longint      log10_2_q;

	jnd_word_t   pending_jnd [$];
	int          errors = 0;
	int          words_sent = 0;
	int          words_checked = 0;
	int          zero_seen = 0;
	int          sat_seen = 0;
	bit          send_calm = 1'b0;
	bit          recv_calm = 1'b0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// num/den in q.30, rounded to nearest
	function automatic longint q30_ratio(input logic [63:0] num, input logic [63:0] den);
		return longint'(((num << QF) + (den >> 1)) / den);
	endfunction

	// (a * b) / 2^s rounded half away from zero over the full product
	function automatic longint mul_round_q(input longint a, input longint b, input int s);
		logic [63:0]  ua;
		logic [63:0]  ub;
		logic [127:0] prod;
		logic [62:0]  r;
		ua = (a < 0) ? 64'(-a) : 64'(a);
		ub = (b < 0) ? 64'(-b) : 64'(b);
		prod = 128'(ua) * 128'(ub);
		prod = prod + (128'd1 << (s - 1));
		r = 63'(prod >> s);
		return ((a < 0) != (b < 0)) ? -longint'({1'b0, r}) : longint'({1'b0, r});
	endfunction

	// expected index word for one luminance
	function automatic jnd_word_t predict_jnd(input logic [LUM_W-1:0] x);
		int          p;
		int          k;
		logic [30:0] nrm;
		logic [63:0] idx;
		logic [63:0] rem;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] frac;
		logic [63:0] mag;
		longint      l2;
		longint      t;
		longint      acc;
		longint      jv;
		jnd_word_t   res;
		if (x == '0) begin
			res.jnd_index = JND_INVALID;
			res.index_valid = 1'b0;
			return res;
		end
		// log2 from leading one plus interpolated mantissa table
		p = LUM_W - 1;
		while (p > 0 && !x[p])
			p--;
		nrm = 31'(x << (LUM_W - 1 - p));
		idx = 64'(nrm >> MANT_SH);
		rem = 64'(nrm) & ((64'd1 << MANT_SH) - 64'd1);
		lo = log2_tab[idx];
		hi = log2_tab[idx + 1];
		frac = lo + (((hi - lo) * rem + (64'd1 << (MANT_SH - 1))) >> MANT_SH);
		l2 = (longint'(p) - LUM_FRAC_BITS) * (longint'(1) <<< QF) + longint'(frac);
		t = mul_round_q(l2, log10_2_q, QF);
		// horner evaluation of the polynomial in log10(L)
		acc = gsdf_c[8];
		for (k = 7; k >= 0; k--)
			acc = mul_round_q(acc, t, QF) + gsdf_c[k];
		// round to the output format and saturate
		mag = ((acc < 0) ? 64'(-acc) : 64'(acc)) + (64'd1 << (QF - OUT_FRAC_BITS - 1));
		mag = mag >> (QF - OUT_FRAC_BITS);
		jv = (acc < 0) ? -longint'(mag) : longint'(mag);
		if (jv > JND_MAX)
			jv = JND_MAX;
		if (jv < JND_MIN)
			jv = JND_MIN;
		res.jnd_index = JND_W'(jv);
		res.index_valid = 1'b1;
		return res;
	endfunction

	// random luminance, weighted toward the display range and table edges
	function automatic logic [LUM_W-1:0] draw_luminance();
		logic [LUM_W-1:0] w;
		logic [7:0]       idx;
		logic [22:0]      rem;
		case ($urandom_range(0, 9))
			0: w = '0;
			1, 2: w = $urandom;
			3, 4, 5: w = $urandom_range(3277, 262144000);
			6, 7: w = ($urandom | 32'h8000_0000) >> $urandom_range(0, 31);
			8: begin
				w = 32'd1 << $urandom_range(0, 31);
				w = w + $urandom_range(0, 2) - 1;
			end
			default: begin
				idx = 8'($urandom_range(0, 255));
				case ($urandom_range(0, 2))
					0: rem = '0;
					1: rem = '1;
					default: rem = 23'd1 << 22;
				endcase
				w = {1'b1, idx, rem} >> $urandom_range(0, 31);
			end
		endcase
		return w;
	endfunction

	// offer one luminance word after a random gap and record its expected index
	task automatic send_luminance(input logic [LUM_W-1:0] w, input bit known,
			input jnd_word_t typed);
		int unsigned gap;
		jnd_word_t   want;
		gap = send_calm ? 0 : $urandom_range(0, MAX_WAIT);
		if ($urandom_range(0, 24) == 0)
			send_calm = !send_calm;
		if (gap > 0) begin
			lum_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		lum_ch.valid <= 1'b1;
		lum_ch.luminance <= w;
		do @(posedge clk); while (lum_ch.ready !== 1'b1);
		want = known ? typed : predict_jnd(w);
		pending_jnd.push_back(want);
		words_sent++;
	endtask

	// stimulus and end of run
	initial begin
		int          k;
		int          b;
		int          i;
		logic [63:0] m;
		logic [63:0] r;
		jnd_word_t   typed;
		for (k = 0; k <= (1 << LOG_TABLE_BITS); k++) begin
			if (k == (1 << LOG_TABLE_BITS)) begin
				r = 64'd1 << QF;
			end else begin
				m = (64'd1 << QF) + (64'(k) << (QF - LOG_TABLE_BITS));
				r = '0;
				for (b = QF - 1; b >= 0; b--) begin
					m = (m * m + (64'd1 << (QF - 1))) >> QF;
					if (m >= (64'd2 << QF)) begin
						m = m >> 1;
						r[b] = 1'b1;
					end
				end
			end
			log2_tab[k] = r;
		end
		log10_2_q = q30_ratio(64'd3010299957, 64'd10000000000);
		gsdf_c[0] = q30_ratio(64'd71498068, 64'd1000000);
		gsdf_c[1] = q30_ratio(64'd94593053, 64'd1000000);
		gsdf_c[2] = q30_ratio(64'd41912053, 64'd1000000);
		gsdf_c[3] = q30_ratio(64'd98247004, 64'd10000000);
		gsdf_c[4] = q30_ratio(64'd28175407, 64'd100000000);
		gsdf_c[5] = -q30_ratio(64'd11878455, 64'd10000000);
		gsdf_c[6] = -q30_ratio(64'd18014349, 64'd100000000);
		gsdf_c[7] = q30_ratio(64'd14710899, 64'd100000000);
		gsdf_c[8] = -q30_ratio(64'd17046845, 64'd1000000000);

		arst_n = 1'b0;
		lum_ch.valid = 1'b0;
		lum_ch.luminance = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed rows
		for (i = 0; i < N_ROWS; i++) begin
			typed.jnd_index = LUM_ROWS[i].jnd_index;
			typed.index_valid = LUM_ROWS[i].index_valid;
			send_luminance(LUM_ROWS[i].luminance, LUM_ROWS[i].known, typed);
		end

		// random words, with one full drain halfway through
		for (i = 0; i < RAND_WORDS; i++) begin
			if (i == RAND_WORDS / 2) begin
				lum_ch.valid <= 1'b0;
				while (pending_jnd.size() != 0)
					@(posedge clk);
			end
			send_luminance(draw_luminance(), 1'b0, '0);
		end
		lum_ch.valid <= 1'b0;

		while (pending_jnd.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run covered %0d luminance words and %0d index words checked",
			words_sent, words_checked);
		$display("of these %0d had zero luminance and %0d saturated the index",
			zero_seen, sat_seen);
		if (errors == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	// index channel: random stalls, compare each word with the oldest expectation
	initial begin
		int unsigned stall;
		jnd_word_t   want;
		jnd_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = recv_calm ? 0 : $urandom_range(0, MAX_WAIT);
			if ($urandom_range(0, 24) == 0)
				recv_calm = !recv_calm;
			if (stall > 0) begin
				jnd_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			jnd_ch.ready <= 1'b1;
			do @(posedge clk); while (jnd_ch.valid !== 1'b1);
			if (pending_jnd.size() == 0) begin
				$error("index word with no expectation: jnd_index %0d index_valid %0b",
					jnd_ch.jnd_index, jnd_ch.index_valid);
				errors++;
			end else begin
				want = pending_jnd.pop_front();
				words_checked++;
				if (!want.index_valid)
					zero_seen++;
				else if (want.jnd_index == JND_W'(JND_MAX) || want.jnd_index == JND_W'(JND_MIN))
					sat_seen++;
				if (jnd_ch.jnd_index !== want.jnd_index) begin
					$error("jnd_index: expected %0d, got %0d",
						want.jnd_index, jnd_ch.jnd_index);
					errors++;
				end
				if (jnd_ch.index_valid !== want.index_valid) begin
					$error("index_valid: expected %0b, got %0b",
						want.index_valid, jnd_ch.index_valid);
					errors++;
				end
			end
		end
	end

	// hard limit on run time
	initial begin
		#2_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/gsdf_pkg.sv
src/gsdf_lum_if.sv
src/gsdf_jnd_if.sv
src/gsdf_log_front.sv
src/gsdf_horner_step.sv
src/gsdf_out_stage.sv
src/gsdf_luminance_to_jnd_index_unit.sv
src/gsdf_checker.sv
sim/gsdf_luminance_to_jnd_index_unit_tb.sv
